// File: sv/gcps_pkg.sv
package gcps_pkg;

    localparam int MAX_RESULTS         = 64;
    localparam int RES_W               = $clog2(MAX_RESULTS + 1);
    localparam int DEF_GROUPS          = 4;
    localparam int DEF_COILS_PER_GROUP = 16;
    localparam int GRP_W_MAX           = 3;
    localparam int CNT_W_MAX           = 7;
    localparam int TBL_AW_MAX          = 9;
    localparam int CMD_QUEUE_DEPTH     = 4;
    localparam int INTERVAL_REGS       = 4;
    localparam int CFG_IDX_W           = 3;

    localparam logic [31:0] INTERVAL_RESET    = 32'd10000;
    localparam logic [7:0]  QUEUE_CAP_RESET   = 8'd16;
    localparam logic [4:0]  BATCH_LIMIT_RESET = 5'd4;

    localparam logic [7:0] FRAME_START = 8'hC0;
    localparam logic [7:0] FRAME_CMD   = 8'h69;
    localparam logic [7:0] FRAME_LEN   = 8'h02;
    localparam logic [7:0] ESC_BYTE    = 8'h5C;
    localparam logic [7:0] ESC_SUB     = 8'hC5;

    typedef enum logic {
        FUNC_REGISTER = 1'b0,
        FUNC_TICK     = 1'b1
    } func_t;

    typedef enum logic {
        KIND_ACK  = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    typedef enum logic {
        ST_OK   = 1'b0,
        ST_FULL = 1'b1
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL_0  = 3'd0,
        CFG_INTERVAL_1  = 3'd1,
        CFG_INTERVAL_2  = 3'd2,
        CFG_INTERVAL_3  = 3'd3,
        CFG_QUEUE_CAP   = 3'd4,
        CFG_BATCH_LIMIT = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SCAN,
        F_FLUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_LOAD
    } back_state_t;

    typedef struct packed {
        logic [INTERVAL_REGS-1:0][31:0] interval;
        logic [7:0]                     queue_cap;
        logic [4:0]                     batch_limit;
    } cfg_t;

    typedef struct packed {
        logic                 is_ack;
        logic                 status;
        logic [1:0]           out_group;
        logic [15:0]          addr;
        logic [GRP_W_MAX-1:0] grp;
        logic [RES_W-1:0]     batch;
        logic [CNT_W_MAX-1:0] cnt;
        logic                 last;
    } cmd_t;

    typedef struct packed {
        logic                  en;
        logic [TBL_AW_MAX-1:0] addr;
        logic [15:0]           data;
    } tbl_wr_t;

    function automatic logic [7:0] frame_sum(input logic [15:0] addr);
        logic [7:0] c;
        c = FRAME_START ^ FRAME_CMD ^ FRAME_LEN ^ addr[7:0] ^ addr[15:8];
        if (c == ESC_BYTE)
        begin
            c = ESC_SUB;
        end
        return c;
    endfunction

endpackage

// File: sv/gcps_regs.sv
module gcps_regs
    import gcps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_INTERVAL_0:  cfg_next.interval[0]  = cfg_data;
                CFG_INTERVAL_1:  cfg_next.interval[1]  = cfg_data;
                CFG_INTERVAL_2:  cfg_next.interval[2]  = cfg_data;
                CFG_INTERVAL_3:  cfg_next.interval[3]  = cfg_data;
                CFG_QUEUE_CAP:   cfg_next.queue_cap    = cfg_data[7:0];
                CFG_BATCH_LIMIT: cfg_next.batch_limit  = cfg_data[4:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval    <= {INTERVAL_REGS{INTERVAL_RESET}};
            cfg_reg.queue_cap   <= QUEUE_CAP_RESET;
            cfg_reg.batch_limit <= BATCH_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/gcps_fifo.sv
module gcps_fifo
    import gcps_pkg::*;
#(
    parameter int DEPTH = CMD_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t pop_data,
    output logic full,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/gcps_front.sv
module gcps_front
    import gcps_pkg::*;
#(
    parameter int GROUPS          = DEF_GROUPS,
    parameter int COILS_PER_GROUP = DEF_COILS_PER_GROUP
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [15:0] coil_address,
    input  logic [1:0]  group_select,
    input  logic [31:0] now_ms,
    input  logic [7:0]  queue_used,
    input  cfg_t        cfg,
    output logic        q_push,
    output cmd_t        q_data,
    input  logic        q_full,
    output tbl_wr_t     tbl_wr
);

    localparam int GW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CNTW = $clog2(COILS_PER_GROUP + 1);
    localparam int AW   = (GROUPS * COILS_PER_GROUP > 1) ? $clog2(GROUPS * COILS_PER_GROUP) : 1;

    front_state_t     state_reg;
    front_state_t     state_next;
    logic [CNTW-1:0]  count_reg     [GROUPS];
    logic [CNTW-1:0]  count_next    [GROUPS];
    logic [31:0]      last_poll_reg [GROUPS];
    logic [31:0]      last_poll_next[GROUPS];
    logic [GW-1:0]    g_reg;
    logic [GW-1:0]    g_next;
    logic [RES_W-1:0] n_reg;
    logic [RES_W-1:0] n_next;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    cmd_t             pend_reg;
    cmd_t             pend_next;
    logic [31:0]      now_reg;
    logic [31:0]      now_next;
    logic [7:0]       used_reg;
    logic [7:0]       used_next;

    logic             accept;
    logic             sel_ok;
    logic [GW-1:0]    sel_idx;
    logic [CNTW-1:0]  sel_cnt;
    logic             has_room;
    cmd_t             ack_cmd;

    logic [CNTW-1:0]  cur_cnt;
    logic [1:0]       ivl_idx;
    logic             fire;
    logic [8:0]       occ;
    logic [8:0]       avail;
    logic [8:0]       room;
    logic [8:0]       b_lim;
    logic [8:0]       b_avail;
    logic [8:0]       b_room;
    logic [RES_W-1:0] batch;
    cmd_t             burst_cmd;
    logic             scan_done;

    assign accept  = in_valid && in_ready;
    assign sel_ok  = int'(group_select) < GROUPS;
    assign sel_idx = GW'(group_select);
    assign sel_cnt = count_reg[sel_idx];
    assign has_room = sel_ok && (sel_cnt < CNTW'(COILS_PER_GROUP));

    always_comb
    begin
        ack_cmd           = '0;
        ack_cmd.is_ack    = 1'b1;
        ack_cmd.status    = has_room ? ST_OK : ST_FULL;
        ack_cmd.out_group = group_select;
        ack_cmd.addr      = coil_address;
        ack_cmd.last      = 1'b1;
    end

    assign cur_cnt = count_reg[g_reg];
    assign ivl_idx = (int'(g_reg) < INTERVAL_REGS) ? 2'(g_reg) : 2'(INTERVAL_REGS - 1);
    assign fire    = (cur_cnt != '0)
                     && ((now_reg - last_poll_reg[g_reg]) >= cfg.interval[ivl_idx]);
    assign occ     = {1'b0, used_reg} + 9'(n_reg);
    assign avail   = ({1'b0, cfg.queue_cap} > occ) ? {1'b0, cfg.queue_cap} - occ : 9'd0;
    assign room    = 9'(MAX_RESULTS) - 9'(n_reg);
    assign b_lim   = (9'(cur_cnt) < 9'(cfg.batch_limit)) ? 9'(cur_cnt) : 9'(cfg.batch_limit);
    assign b_avail = (b_lim < avail) ? b_lim : avail;
    assign b_room  = (b_avail < room) ? b_avail : room;
    assign batch   = RES_W'(b_room);
    assign scan_done = (g_reg == GW'(GROUPS - 1));

    always_comb
    begin
        burst_cmd           = '0;
        burst_cmd.is_ack    = 1'b0;
        burst_cmd.status    = ST_OK;
        burst_cmd.out_group = 2'(g_reg);
        burst_cmd.grp       = GRP_W_MAX'(g_reg);
        burst_cmd.batch     = batch;
        burst_cmd.cnt       = CNT_W_MAX'(cur_cnt);
        burst_cmd.last      = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && (func == FUNC_TICK))
                begin
                    state_next = F_SCAN;
                end
            end
            F_SCAN:
            begin
                if (!q_full && scan_done)
                begin
                    state_next = F_FLUSH;
                end
            end
            F_FLUSH:
            begin
                if (!pend_valid_reg || !q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        q_push          = 1'b0;
        q_data          = ack_cmd;
        tbl_wr          = '0;
        count_next      = count_reg;
        last_poll_next  = last_poll_reg;
        g_next          = g_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        now_next        = now_reg;
        used_next       = used_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = !q_full;
                if (accept)
                begin
                    if (func == FUNC_REGISTER)
                    begin
                        q_push = 1'b1;
                        if (has_room)
                        begin
                            tbl_wr.en   = 1'b1;
                            tbl_wr.addr = TBL_AW_MAX'(AW'(int'(sel_idx) * COILS_PER_GROUP
                                                         + int'(sel_cnt)));
                            tbl_wr.data = coil_address;
                            count_next[sel_idx] = sel_cnt + CNTW'(1);
                        end
                    end
                    else
                    begin
                        now_next        = now_ms;
                        used_next       = queue_used;
                        g_next          = '0;
                        n_next          = '0;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            F_SCAN:
            begin
                if (!q_full)
                begin
                    if (fire)
                    begin
                        last_poll_next[g_reg] = now_reg;
                        if (batch != '0)
                        begin
                            if (pend_valid_reg)
                            begin
                                q_push = 1'b1;
                                q_data = pend_reg;
                            end
                            pend_next       = burst_cmd;
                            pend_valid_next = 1'b1;
                            n_next          = n_reg + batch;
                        end
                    end
                    g_next = g_reg + GW'(1);
                end
            end
            F_FLUSH:
            begin
                if (pend_valid_reg && !q_full)
                begin
                    q_push          = 1'b1;
                    q_data          = pend_reg;
                    q_data.last     = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            g_reg          <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < GROUPS; i++)
            begin
                count_reg[i]     <= '0;
                last_poll_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            g_reg          <= g_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            last_poll_reg  <= last_poll_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        now_reg  <= now_next;
        used_reg <= used_next;
    end

endmodule

// File: sv/gcps_back.sv
module gcps_back
    import gcps_pkg::*;
#(
    parameter int GROUPS          = DEF_GROUPS,
    parameter int COILS_PER_GROUP = DEF_COILS_PER_GROUP
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        q_data,
    input  logic        q_empty,
    output logic        q_pop,
    input  tbl_wr_t     tbl_wr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic        status,
    output logic [1:0]  req_group,
    output logic [15:0] req_address,
    output logic [7:0]  frame_checksum,
    output logic        last
);

    localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CNTW  = $clog2(COILS_PER_GROUP + 1);
    localparam int OFFW  = (COILS_PER_GROUP > 1) ? $clog2(COILS_PER_GROUP) : 1;
    localparam int DEPTH = GROUPS * COILS_PER_GROUP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [15:0]      coil_mem [DEPTH];
    logic [15:0]      rd_data_reg;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [OFFW-1:0]  offset_reg [GROUPS];
    logic [GW-1:0]    grp_reg;
    logic [1:0]       out_grp_reg;
    logic [RES_W-1:0] rem_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             last_cmd_reg;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic             out_status_reg;
    logic [1:0]       out_group_reg;
    logic [15:0]      out_addr_reg;
    logic [7:0]       out_sum_reg;
    logic             out_last_reg;

    logic             slot_free;
    logic             latch;
    logic             rd_en;
    logic             load_ack;
    logic             load_req;
    logic [OFFW-1:0]  cur_off;
    logic [OFFW-1:0]  off;
    logic [CNTW-1:0]  off_inc;
    logic [OFFW-1:0]  off_next;
    logic [AW-1:0]    rd_addr;

    assign slot_free = !out_valid_reg || out_ready;

    assign cur_off  = offset_reg[grp_reg];
    assign off      = (CNTW'(cur_off) < cnt_reg) ? cur_off : '0;
    assign off_inc  = CNTW'(off) + CNTW'(1);
    assign off_next = (off_inc == cnt_reg) ? '0 : OFFW'(off_inc);
    assign rd_addr  = AW'(int'(grp_reg) * COILS_PER_GROUP + int'(off));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && !q_data.is_ack)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = (rem_reg == RES_W'(1)) ? B_IDLE : B_READ;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        latch    = 1'b0;
        rd_en    = 1'b0;
        load_ack = 1'b0;
        load_req = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_data.is_ack)
                    begin
                        q_pop    = slot_free;
                        load_ack = slot_free;
                    end
                    else
                    begin
                        q_pop = 1'b1;
                        latch = 1'b1;
                    end
                end
            end
            B_READ:
            begin
                rd_en = 1'b1;
            end
            B_LOAD:
            begin
                load_req = slot_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr.en)
        begin
            coil_mem[tbl_wr.addr[AW-1:0]] <= tbl_wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= coil_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < GROUPS; i++)
            begin
                offset_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (rd_en)
            begin
                offset_reg[grp_reg] <= off_next;
            end
            if (load_ack || load_req)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (latch)
        begin
            grp_reg      <= GW'(q_data.grp);
            out_grp_reg  <= q_data.out_group;
            rem_reg      <= q_data.batch;
            cnt_reg      <= CNTW'(q_data.cnt);
            last_cmd_reg <= q_data.last;
        end
        else if (load_req)
        begin
            rem_reg <= rem_reg - RES_W'(1);
        end
        if (load_ack)
        begin
            out_kind_reg   <= KIND_ACK;
            out_status_reg <= q_data.status;
            out_group_reg  <= q_data.out_group;
            out_addr_reg   <= q_data.addr;
            out_sum_reg    <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (load_req)
        begin
            out_kind_reg   <= KIND_READ;
            out_status_reg <= ST_OK;
            out_group_reg  <= out_grp_reg;
            out_addr_reg   <= rd_data_reg;
            out_sum_reg    <= frame_sum(rd_data_reg);
            out_last_reg   <= last_cmd_reg && (rem_reg == RES_W'(1));
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_kind_reg;
    assign status         = out_status_reg;
    assign req_group      = out_group_reg;
    assign req_address    = out_addr_reg;
    assign frame_checksum = out_sum_reg;
    assign last           = out_last_reg;

endmodule

// File: sv/grouped_coil_poll_scheduler_top.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    func, coil_address, group_select, now_ms,
//                                             queue_used
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
// out       output     out_valid / out_ready  kind, status, req_group, req_address,
//                                             frame_checksum, last
//
// A register transaction is accepted in the idle state; a tick walks the groups
// at one group a cycle unless the command queue is full, then flushes the held request.
// The back end serves each read request as a coil table read, then an output load,
// and loads each acknowledge straight from the queue once the output register is free.
// Reset clears all control state and group counters; the coil table needs no clearing pass.
// A full command queue stalls the front end; a stalled output register stalls the back end.
module grouped_coil_poll_scheduler_top
    import gcps_pkg::*;
#(
    parameter int GROUPS          = DEF_GROUPS,
    parameter int COILS_PER_GROUP = DEF_COILS_PER_GROUP
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [15:0]          coil_address,
    input  logic [1:0]           group_select,
    input  logic [31:0]          now_ms,
    input  logic [7:0]           queue_used,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 kind,
    output logic                 status,
    output logic [1:0]           req_group,
    output logic [15:0]          req_address,
    output logic [7:0]           frame_checksum,
    output logic                 last
);

    cfg_t    cfg;
    logic    q_push;
    cmd_t    q_push_data;
    logic    q_pop;
    cmd_t    q_pop_data;
    logic    q_full;
    logic    q_empty;
    tbl_wr_t tbl_wr;

    gcps_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gcps_front #(
        .GROUPS          (GROUPS),
        .COILS_PER_GROUP (COILS_PER_GROUP)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .coil_address (coil_address),
        .group_select (group_select),
        .now_ms       (now_ms),
        .queue_used   (queue_used),
        .cfg          (cfg),
        .q_push       (q_push),
        .q_data       (q_push_data),
        .q_full       (q_full),
        .tbl_wr       (tbl_wr)
    );

    gcps_fifo #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    gcps_back #(
        .GROUPS          (GROUPS),
        .COILS_PER_GROUP (COILS_PER_GROUP)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_data         (q_pop_data),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .tbl_wr         (tbl_wr),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .status         (status),
        .req_group      (req_group),
        .req_address    (req_address),
        .frame_checksum (frame_checksum),
        .last           (last)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from empty queue");

    a_ack_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_ACK)) |-> (last && (frame_checksum == 8'h00)))
        else $error("acknowledge not marked last or carries a checksum");

    a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_READ)) |-> ((status == ST_OK) && (frame_checksum != ESC_BYTE)))
        else $error("read request with bad status or unescaped checksum");

endmodule

// File: sim/tb.sv
module tb;
    import gcps_pkg::*;

    localparam int GROUP_CNT = DEF_GROUPS;
    localparam int COIL_CNT  = DEF_COILS_PER_GROUP;
    localparam logic [7:0] HDR_SUM = FRAME_START ^ FRAME_CMD ^ FRAME_LEN;

    typedef struct packed {
        func_t       fn;
        logic [1:0]  sel;
        logic [15:0] addr;
        logic [31:0] now;
        logic [7:0]  used;
    } sched_item_t;

    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [1:0]  grp;
        logic [15:0] addr;
        logic [7:0]  sum;
        logic        last;
    } poll_rec_t;

    typedef struct packed {
        cfg_idx_t    idx;
        logic [31:0] data;
    } reg_write_t;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic                 func           = 1'b0;
    logic [15:0]          coil_address   = '0;
    logic [1:0]           group_select   = '0;
    logic [31:0]          now_ms         = '0;
    logic [7:0]           queue_used     = '0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [31:0]          cfg_data       = '0;
    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic                 kind;
    logic                 status;
    logic [1:0]           req_group;
    logic [15:0]          req_address;
    logic [7:0]           frame_checksum;
    logic                 last;

    // poll scheduler state as predicted
    logic [15:0] coil_tbl [GROUP_CNT][COIL_CNT];
    int          grp_count [GROUP_CNT];
    int          grp_off [GROUP_CNT];
    logic [31:0] grp_last [GROUP_CNT];
    logic [31:0] ivl_tbl [GROUP_CNT];
    int          q_cap;
    int          batch_lim;

    sched_item_t item_q[$];
    reg_write_t  cfg_q[$];
    poll_rec_t   awaited_results[$];
    sched_item_t drv_item;
    reg_write_t  reg_wr;
    poll_rec_t   seen;
    poll_rec_t   want;

    int          items_queued = 0;
    int          items_sent   = 0;
    int          cfg_pushed   = 0;
    int          cfg_done     = 0;
    int          err_cnt      = 0;
    bit          in_taken     = 1'b0;
    bit          cfg_taken    = 1'b0;
    bit          gaps_on      = 1'b1;
    int          tx_gap       = 0;
    int          rx_gap       = 0;
    int          rx_hold      = 0;
    logic [31:0] ms_now       = '0;
    int          cap_now      = int'(QUEUE_CAP_RESET);

    grouped_coil_poll_scheduler_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .coil_address   (coil_address),
        .group_select   (group_select),
        .now_ms         (now_ms),
        .queue_used     (queue_used),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .status         (status),
        .req_group      (req_group),
        .req_address    (req_address),
        .frame_checksum (frame_checksum),
        .last           (last)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] frame_check(input logic [15:0] a);
        logic [7:0] x;
        x = HDR_SUM ^ a[7:0] ^ a[15:8];
        return (x == ESC_BYTE) ? ESC_SUB : x;
    endfunction

    task automatic predict_schedule(input sched_item_t it);
        poll_rec_t   r;
        logic [31:0] since;
        logic [15:0] a;
        int          issued;
        int          occ;
        int          room;
        int          burst;
        int          off;
        issued = 0;
        if (it.fn == FUNC_REGISTER)
        begin
            r.kind = KIND_ACK;
            r.grp  = it.sel;
            r.addr = it.addr;
            r.sum  = '0;
            r.last = 1'b1;
            if (grp_count[it.sel] < COIL_CNT)
            begin
                coil_tbl[it.sel][grp_count[it.sel]] = it.addr;
                grp_count[it.sel]++;
                r.status = ST_OK;
            end
            else
            begin
                r.status = ST_FULL;
            end
            awaited_results.insert(awaited_results.size(), r);
        end
        else
        begin
            for (int g = 0; g < GROUP_CNT; g++)
            begin
                if (grp_count[g] == 0)
                    continue;
                since = it.now - grp_last[g];
                if (since < ivl_tbl[g])
                    continue;
                grp_last[g] = it.now;
                occ   = it.used + issued;
                room  = (q_cap > occ) ? q_cap - occ : 0;
                burst = grp_count[g];
                if (burst > batch_lim)
                    burst = batch_lim;
                if (burst > room)
                    burst = room;
                if (burst > MAX_RESULTS - issued)
                    burst = MAX_RESULTS - issued;
                for (int k = 0; k < burst; k++)
                begin
                    off = (grp_off[g] < grp_count[g]) ? grp_off[g] : 0;
                    a = coil_tbl[g][off];
                    grp_off[g] = (off + 1) % grp_count[g];
                    r.kind   = KIND_READ;
                    r.status = ST_OK;
                    r.grp    = g[1:0];
                    r.addr   = a;
                    r.sum    = frame_check(a);
                    r.last   = 1'b0;
                    awaited_results.insert(awaited_results.size(), r);
                    issued++;
                end
            end
            if (issued > 0)
            begin
                r = awaited_results.pop_back();
                r.last = 1'b1;
                awaited_results.insert(awaited_results.size(), r);
            end
        end
    endtask

    task automatic apply_reg(input reg_write_t w);
        case (w.idx)
            CFG_INTERVAL_0:  ivl_tbl[0] = w.data;
            CFG_INTERVAL_1:  ivl_tbl[1] = w.data;
            CFG_INTERVAL_2:  ivl_tbl[2] = w.data;
            CFG_INTERVAL_3:  ivl_tbl[3] = w.data;
            CFG_QUEUE_CAP:   q_cap = int'(w.data[7:0]);
            CFG_BATCH_LIMIT: batch_lim = int'(w.data[4:0]);
            default: ;
        endcase
    endtask

    // driver: input and register channels
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            in_taken = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                tx_gap = $urandom_range(0, 18);
                in_valid <= 1'b0;
            end
            else if (item_q.size() != 0)
            begin
                drv_item = item_q.pop_front();
                func         <= drv_item.fn;
                coil_address <= drv_item.addr;
                group_select <= drv_item.sel;
                now_ms       <= drv_item.now;
                queue_used   <= drv_item.used;
                in_valid     <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        if (!cfg_valid || cfg_taken)
        begin
            cfg_taken = 1'b0;
            if (cfg_q.size() != 0)
            begin
                reg_wr = cfg_q.pop_front();
                cfg_index <= reg_wr.idx;
                cfg_data  <= reg_wr.data;
                cfg_valid <= 1'b1;
            end
            else
            begin
                cfg_valid <= 1'b0;
            end
        end
    end

    // result receiver: long hold, then random stall bursts
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            out_ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            rx_gap = $urandom_range(0, 18);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_schedule(drv_item);
                items_sent++;
                in_taken = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(reg_wr);
                cfg_done++;
                cfg_taken = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                seen = {kind, status, req_group, req_address, frame_checksum, last};
                if (awaited_results.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t unexpected result: expected none, actual %0d/%0d/%0d %s",
                             $time, seen.kind, seen.status, seen.grp,
                             $sformatf("%h/%h/%0d", seen.addr, seen.sum, seen.last));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (seen !== want)
                    begin
                        err_cnt++;
                        $display("%0t mismatch: expected %0d/%0d/%0d/%h/%h/%0d %s",
                                 $time, want.kind, want.status, want.grp, want.addr,
                                 want.sum, want.last,
                                 $sformatf("actual %0d/%0d/%0d/%h/%h/%0d",
                                           seen.kind, seen.status, seen.grp,
                                           seen.addr, seen.sum, seen.last));
                    end
                end
            end
        end
    end

    task automatic push_item(input sched_item_t it);
        item_q.insert(item_q.size(), it);
        items_queued++;
    endtask

    task automatic push_coil(input logic [1:0] sel, input logic [15:0] a);
        sched_item_t it;
        it.fn   = FUNC_REGISTER;
        it.sel  = sel;
        it.addr = a;
        it.now  = $urandom();
        it.used = 8'($urandom_range(0, 255));
        push_item(it);
    endtask

    task automatic push_tick(input logic [31:0] t, input logic [7:0] used);
        sched_item_t it;
        it.fn   = FUNC_TICK;
        it.sel  = 2'($urandom_range(0, 3));
        it.addr = 16'($urandom_range(0, 65535));
        it.now  = t;
        it.used = used;
        push_item(it);
    endtask

    task automatic settle();
        while (!(items_sent == items_queued && awaited_results.size() == 0))
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] i0, input logic [31:0] i1,
                                input logic [31:0] i2, input logic [31:0] i3,
                                input int cap, input int batch);
        settle();
        cfg_q.insert(cfg_q.size(), {CFG_INTERVAL_0, i0});
        cfg_q.insert(cfg_q.size(), {CFG_INTERVAL_1, i1});
        cfg_q.insert(cfg_q.size(), {CFG_INTERVAL_2, i2});
        cfg_q.insert(cfg_q.size(), {CFG_INTERVAL_3, i3});
        cfg_q.insert(cfg_q.size(), {CFG_QUEUE_CAP, 32'(cap)});
        cfg_q.insert(cfg_q.size(), {CFG_BATCH_LIMIT, 32'(batch)});
        cfg_pushed += 6;
        cap_now = cap;
        while (cfg_done != cfg_pushed)
            @(posedge clk);
    endtask

    task automatic add_traffic(input int n, input int span);
        logic [7:0] used;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                push_coil(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
            end
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    ms_now = $urandom();
                else
                    ms_now = ms_now + $urandom_range(0, span);
                if ($urandom_range(0, 3) == 0)
                    used = 8'($urandom_range(0, 255));
                else
                    used = 8'($urandom_range(0, cap_now));
                push_tick(ms_now, used);
            end
        end
    endtask

    initial
    begin
        for (int g = 0; g < GROUP_CNT; g++)
        begin
            grp_count[g] = 0;
            grp_off[g]   = 0;
            grp_last[g]  = '0;
            ivl_tbl[g]   = INTERVAL_RESET;
        end
        q_cap     = int'(QUEUE_CAP_RESET);
        batch_lim = int'(BATCH_LIMIT_RESET);
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_tick(32'd0, 8'd0);
        for (int i = 0; i < 16; i++)
            push_coil(2'd0, 16'(i) * 16'h1111);
        push_coil(2'd0, 16'h1234);
        push_coil(2'd1, 16'h8000);
        push_coil(2'd2, 16'h00F7);
        push_coil(2'd3, 16'h006E);
        push_tick(32'd5000, 8'd0);
        push_tick(32'd10000, 8'd0);
        push_tick(32'd20000, 8'd255);
        push_tick(32'hFFFF_FFFF, 8'd15);

        program_regs(32'd0, 32'hFFFF_FFFF, 32'd1, 32'd100, 255, 16);
        ms_now = 32'hFFFF_FFFE;
        push_tick(ms_now, 8'd0);
        add_traffic(80, 150);

        program_regs(32'd5, 32'd0, 32'd20, 32'd3, 1, 0);
        add_traffic(20, 30);

        program_regs($urandom_range(0, 40), $urandom_range(0, 40),
                     $urandom_range(0, 40), $urandom_range(0, 40), 8, 1);
        rx_hold = 400;
        add_traffic(80, 60);

        for (int p = 0; p < 3; p++)
        begin
            program_regs($urandom_range(0, 60), $urandom_range(0, 60),
                         $urandom_range(0, 60), $urandom_range(0, 60),
                         $urandom_range(0, 1) ? $urandom_range(1, 24) : $urandom_range(25, 255),
                         $urandom_range(1, 16));
            add_traffic(70, 90);
        end

        program_regs(32'd10, 32'd20, 32'd30, 32'd40, 64, 16);
        gaps_on = 1'b0;
        add_traffic(60, 60);

        settle();
        if (err_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
